### src/stfr_pkg.sv
// Shared constants, codes and types of the swap-to-front Rice symbol encoder.
// No dependencies; compile first.
package stfr_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int SYM_W         = 8;
  localparam int OP_W          = 2;
  localparam int K_W           = 4;
  localparam int PBITS_W       = 7;
  localparam int PCNT_W        = 3;
  localparam int OBUF_W        = 24;

  localparam logic [OP_W-1:0] OP_ENCODE = 2'd0;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd1;
  localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

  localparam logic [K_W-1:0] K_INIT = 4'd2;
  localparam logic [K_W-1:0] K_MAX  = 4'd15;

  typedef logic [SYM_W-1:0] sym_t;

  // Bytes and updated coder state produced by one item
  typedef struct packed {
    logic [OBUF_W-1:0]  bytes;
    logic [1:0]         n;
    logic [PBITS_W-1:0] pbits;
    logic [PCNT_W-1:0]  pcnt;
    logic [K_W-1:0]     k;
  } pack_res_t;

endpackage

### src/stfr_sym_if.sv
// Input channel of the encoder: valid/ready handshake carrying opcode and symbol.
// Depends on stfr_pkg.
interface stfr_sym_if;
  logic                      valid;
  logic                      ready;
  logic [stfr_pkg::OP_W-1:0]  opcode;
  logic [stfr_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output opcode, output symbol, input ready);
  modport sink (input valid, input opcode, input symbol, output ready);
endinterface

### src/stfr_byte_if.sv
// Output channel of the encoder: valid/ready handshake carrying packed bytes.
// Depends on stfr_pkg.
interface stfr_byte_if;
  logic                       valid;
  logic                       ready;
  logic [stfr_pkg::SYM_W-1:0] out_byte;
  logic                       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

### src/swap_to_front_rice_symbol_encoder.sv
// Swap-to-front adaptive Rice symbol encoder, top level. Uses stfr_pkg, the two
// channel interfaces, stfr_ram for the order and rank tables and stfr_rice_pack.
//
// Each byte symbol is looked up in a rank table, its rank is swapped toward the
// front (to rank*7/8) in a 256-entry permutation, and the old rank is sent as an
// adaptive Rice code, bits packed LSB first into bytes; the last byte an item
// causes carries last=1. Both tables live in synchronous RAMs with registered
// read data, and one item is in work at a time. An encode item passes through
// acceptance with the rank read, the order read of the swap partner, and two
// write-back steps, since each table has one write port and the swap changes
// two entries in each. Flush and the unused opcode go from acceptance to commit.
// Results wait in a three-byte output register, so the next item is accepted
// while they drain; an item only holds in its last cycle if earlier bytes are
// still there. After reset, and after every reinit item, the tables are swept
// back to their initial order at one entry per cycle, all 256 entries, while
// no item is accepted (configuration writes are still taken). Reinit latches
// initial_order at acceptance, so a later write does not disturb the sweep.
module swap_to_front_rice_symbol_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  stfr_sym_if.sink    sym_chan,
  stfr_byte_if.source byte_chan
);
  import stfr_pkg::*;

  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RANK   = 3'd2;
  localparam logic [2:0] ST_ORD    = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0]         state;
  sym_t               sweep_addr;
  logic               sweep_mode;
  logic               initial_order;
  logic [K_W-1:0]     rice_k;
  logic [PBITS_W-1:0] pending_bits;
  logic [PCNT_W-1:0]  pending_count;
  logic [OBUF_W-1:0]  obuf;
  logic [1:0]         out_n;

  // Payload of the item in work
  sym_t      sym_q;
  sym_t      rank_q;
  sym_t      tgt_q;
  sym_t      b_q;
  logic      is_enc;
  pack_res_t res_q;

  logic      in_accept;
  logic      out_accept;
  sym_t      rank_rdata;
  sym_t      order_rdata;
  sym_t      tgt_calc;
  pack_res_t pack_res;
  pack_res_t flush_res;
  pack_res_t keep_res;

  logic      order_we;
  sym_t      order_waddr;
  sym_t      order_wdata;
  logic      rank_we;
  sym_t      rank_waddr;
  sym_t      rank_wdata;

  assign sym_chan.ready     = (state == ST_IDLE);
  assign in_accept          = sym_chan.valid & sym_chan.ready;
  assign byte_chan.valid    = (out_n != 2'd0);
  assign byte_chan.out_byte = obuf[SYM_W-1:0];
  assign byte_chan.last     = (out_n == 2'd1);
  assign out_accept         = byte_chan.valid & byte_chan.ready;

  // Swap partner sits at floor(rank * 7 / 8)
  assign tgt_calc = SYM_W'((11'(rank_rdata) * 11'd7) >> 3);

  always_comb begin
    flush_res.bytes = OBUF_W'(pending_bits);
    flush_res.n     = {1'b0, (pending_count != '0)};
    flush_res.pbits = '0;
    flush_res.pcnt  = '0;
    flush_res.k     = rice_k;

    keep_res.bytes  = '0;
    keep_res.n      = 2'd0;
    keep_res.pbits  = pending_bits;
    keep_res.pcnt   = pending_count;
    keep_res.k      = rice_k;
  end

  stfr_rice_pack u_pack (
    .rank  (rank_q),
    .k     (rice_k),
    .pbits (pending_bits),
    .pcnt  (pending_count),
    .res   (pack_res)
  );

  // Table write ports: the sweep, then the first and second half of the swap.
  // The second half may repeat while the item holds; it rewrites the same values.
  always_comb begin
    order_we    = 1'b0;
    order_waddr = rank_q;
    order_wdata = b_q;
    rank_we     = 1'b0;
    rank_waddr  = b_q;
    rank_wdata  = rank_q;
    unique case (state)
      ST_SWEEP: begin
        order_we    = 1'b1;
        order_waddr = sweep_addr;
        order_wdata = sweep_addr ^ {SYM_W{sweep_mode}};
        rank_we     = 1'b1;
        rank_waddr  = sweep_addr;
        rank_wdata  = sweep_addr ^ {SYM_W{sweep_mode}};
      end
      ST_ORD: begin
        order_we    = 1'b1;
        order_waddr = tgt_q;
        order_wdata = sym_q;
        rank_we     = 1'b1;
        rank_waddr  = sym_q;
        rank_wdata  = tgt_q;
      end
      ST_COMMIT: begin
        order_we    = is_enc;
        rank_we     = is_enc;
      end
      default: begin
        order_we    = 1'b0;
        rank_we     = 1'b0;
      end
    endcase
  end

  stfr_ram #(
    .WIDTH (SYM_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (sym_chan.symbol),
    .rdata (rank_rdata)
  );

  stfr_ram #(
    .WIDTH (SYM_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_order_ram (
    .clk   (clk),
    .we    (order_we),
    .waddr (order_waddr),
    .wdata (order_wdata),
    .raddr (tgt_calc),
    .rdata (order_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_addr    <= '0;
      sweep_mode    <= 1'b0;
      initial_order <= 1'b0;
      rice_k        <= K_INIT;
      pending_bits  <= '0;
      pending_count <= '0;
      out_n         <= 2'd0;
      is_enc        <= 1'b0;
    end else begin
      if (cfg_wen) begin
        initial_order <= cfg_wdata;
      end

      unique case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == sym_t'(ALPHABET_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            unique case (sym_chan.opcode)
              OP_ENCODE: begin
                sym_q <= sym_chan.symbol;
                state <= ST_RANK;
              end
              OP_FLUSH: begin
                res_q  <= flush_res;
                is_enc <= 1'b0;
                state  <= ST_COMMIT;
              end
              OP_REINIT: begin
                rice_k     <= K_INIT;
                sweep_mode <= initial_order;
                sweep_addr <= '0;
                state      <= ST_SWEEP;
              end
              default: begin
                // unused opcode: pass through commit with nothing to emit
                res_q  <= keep_res;
                is_enc <= 1'b0;
                state  <= ST_COMMIT;
              end
            endcase
          end
        end
        ST_RANK: begin
          rank_q <= rank_rdata;
          tgt_q  <= tgt_calc;
          state  <= ST_ORD;
        end
        ST_ORD: begin
          b_q    <= order_rdata;
          res_q  <= pack_res;
          is_enc <= 1'b1;
          state  <= ST_COMMIT;
        end
        ST_COMMIT: begin
          // hold until the output register has drained
          if (out_n == 2'd0) begin
            rice_k        <= res_q.k;
            pending_bits  <= res_q.pbits;
            pending_count <= res_q.pcnt;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Output register: load when empty in commit, otherwise advance on each take
      if (state == ST_COMMIT && out_n == 2'd0) begin
        obuf  <= res_q.bytes;
        out_n <= res_q.n;
      end else if (out_accept) begin
        obuf  <= obuf >> SYM_W;
        out_n <= out_n - 2'd1;
      end
    end
  end

endmodule

### src/stfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/stfr_rice_pack.sv
// Adaptive Rice code of one rank, merged with the pending bits into whole bytes.
// Depends on stfr_pkg.
module stfr_rice_pack (
  input  logic [stfr_pkg::SYM_W-1:0]   rank,
  input  logic [stfr_pkg::K_W-1:0]     k,
  input  logic [stfr_pkg::PBITS_W-1:0] pbits,
  input  logic [stfr_pkg::PCNT_W-1:0]  pcnt,
  output stfr_pkg::pack_res_t          res
);
  import stfr_pkg::*;

  logic [SYM_W-1:0] q;
  logic             esc;
  logic             big;
  logic [17:0]      unary;
  logic [15:0]      low_bits;
  logic [17:0]      code;
  logic [4:0]       len;
  logic [24:0]      acc;
  logic [4:0]       cnt;
  logic [24:0]      rest;
  logic [4:0]       k_sum;

  always_comb begin
    q        = rank >> k;
    esc      = |q[7:3];
    big      = |rank[7:5];
    unary    = (18'd1 << q[2:0]) - 18'd1;
    low_bits = 16'(rank) & ((16'd1 << k) - 16'd1);

    if (esc && big) begin
      code = 18'h001FF | (18'(rank) << 10);
      len  = 5'd18;
    end else if (esc) begin
      code = 18'h000FF | (18'(rank[4:0]) << 9);
      len  = 5'd14;
    end else begin
      code = unary | (18'(low_bits) << ({1'b0, q[2:0]} + 4'd1));
      len  = 5'(q[2:0]) + 5'd1 + 5'(k);
    end

    acc  = 25'(pbits) | (25'(code) << pcnt);
    cnt  = 5'(pcnt) + len;
    rest = acc >> {cnt[4:3], 3'b000};

    // k adaptation: shrink on q zero, grow by floor(log2 q) for q below 8 and by 3 or 4 on escape, saturate at the top
    if (esc) begin
      k_sum = 5'(k) + (big ? 5'd4 : 5'd3);
    end else if (q[2]) begin
      k_sum = 5'(k) + 5'd2;
    end else if (q[1]) begin
      k_sum = 5'(k) + 5'd1;
    end else if (q[0]) begin
      k_sum = 5'(k);
    end else begin
      k_sum = (k == '0) ? 5'd0 : 5'(k) - 5'd1;
    end

    res.bytes = acc[OBUF_W-1:0];
    res.n     = cnt[4:3];
    res.pbits = rest[PBITS_W-1:0];
    res.pcnt  = cnt[2:0];
    res.k     = (k_sum > 5'(K_MAX)) ? K_MAX : k_sum[K_W-1:0];
  end

endmodule

### src/stfr_check.sv
// Port-level checks on the swap-to-front Rice encoder, bound to its top level.
// Depends on swap_to_front_rice_symbol_encoder.
module stfr_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last
);

  // no item is taken right after reset, at the start of the table sweep that follows it
  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready right after reset");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted in consecutive cycles");

  // bytes of one item come out without a gap in the valid
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> out_valid)
    else $error("result bytes ended without last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(last)))
    else $error("stalled output byte changed");

endmodule

bind swap_to_front_rice_symbol_encoder stfr_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sym_chan.valid),
  .in_ready  (sym_chan.ready),
  .out_valid (byte_chan.valid),
  .out_ready (byte_chan.ready),
  .out_byte  (byte_chan.out_byte),
  .last      (byte_chan.last)
);
